/* hw/rtl/nsr_pkg.sv */
// Shared types and constants for the NMEA sentence receiver.
// No dependencies; imported by nsr_framer, nsr_payload_ram and the top level.
package nsr_pkg;

  typedef enum logic {
    CMD_RX   = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BUSY     = 3'd1,
    ST_VALID    = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_CHKSUM   = 3'd5,
    ST_BADEND   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_CHK_HI  = 3'd2,
    PH_CHK_LO  = 3'd3,
    PH_CR      = 3'd4,
    PH_LF      = 3'd5
  } phase_e;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } wr_req_t;

  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharHexA   = 8'h37; // 'A' - 10

  // Uppercase ASCII hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    if (nib <= 4'd9) begin
      return ext + CharZero;
    end else begin
      return ext + CharHexA;
    end
  endfunction

endpackage

/* hw/rtl/nmea_sentence_receiver.sv */
// Top level of the NMEA sentence receiver: stream handshake and output register.
// Depends on nsr_pkg, nsr_framer and nsr_payload_ram.
//
//  Channel   Dir  Sideband  Payload bits (low to high)
//  s_axis    in   tuser=cmd tdata: rx_byte[7:0], read_index[14:8], zero[15]
//  m_axis    out  -         tdata: status[2:0], frame_length[9:3],
//                                  read_data[17:10], zero[23:18]
//
// One beat per cycle unless stalled; a result shows the cycle after its beat.
// The payload RAM has one write and one read port, both used in the accept
// cycle. A stalled output holds its beat and s_axis_tready drops until taken.
// Reset returns to waiting for '$'; the payload RAM is not cleared.
module nmea_sentence_receiver #(
  parameter int unsigned BufferDepth = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte, read_index
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // status, frame_length, read_data
);
  import nsr_pkg::*;

  localparam int unsigned CntW = $clog2(BufferDepth);

  logic             s_acc, step, rd_en, idx_ok;
  cmd_e             cmd;
  logic [7:0]       rx_byte;
  logic [6:0]       read_index;
  status_e          fr_status;
  logic [CntW-1:0]  fr_count, wr_addr;
  wr_req_t          wr_req, wr_gated;
  logic [7:0]       ram_data;

  logic             valid_q;
  status_e          status_q;
  logic [6:0]       len_q;
  logic             rd_sel_q;

  assign cmd        = cmd_e'(s_axis_tuser);
  assign rx_byte    = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[14:8];

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign step          = s_acc && (cmd == CMD_RX);
  assign idx_ok        = ({2'b00, read_index} < 9'(BufferDepth));
  assign rd_en         = s_acc && (cmd == CMD_READ) && idx_ok;

  nsr_framer #(
    .BufferDepth (BufferDepth),
    .CntW        (CntW)
  ) u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (rx_byte),
    .status_o  (fr_status),
    .count_o   (fr_count),
    .wr_o      (wr_req),
    .wr_addr_o (wr_addr)
  );

  assign wr_gated = wr_req;

  nsr_payload_ram #(
    .BufferDepth (BufferDepth),
    .AddrW       (CntW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr_gated),
    .wr_addr_i (wr_addr),
    .rd_en_i   (rd_en),
    .rd_addr_i (CntW'(read_index)),
    .rd_data_o (ram_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      status_q <= step ? fr_status : ST_IDLE;
      len_q    <= 7'(fr_count);
      rd_sel_q <= rd_en;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'b000000, (rd_sel_q ? ram_data : 8'h00), len_q, status_q};

`ifndef SYNTH
  a_rx_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (m_axis_tdata[17:10] == 8'h00))
    else $error("receive beat returned read data");

  a_read_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (cmd == CMD_READ)) |=> (m_axis_tvalid && (m_axis_tdata[2:0] == ST_IDLE)))
    else $error("read beat returned a framing status");
`endif

endmodule

/* hw/rtl/nsr_payload_ram.sv */
// Payload byte store: one synchronous write port, one registered read port.
// Depends on nsr_pkg for the write request type.
module nsr_payload_ram #(
  parameter int unsigned BufferDepth = 128,
  parameter int unsigned AddrW       = 7
) (
  input  logic                clk_i,
  input  nsr_pkg::wr_req_t    wr_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [7:0]          rd_data_o
);
  import nsr_pkg::*;

  logic [7:0] mem_q [BufferDepth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  // Hold the last read while the output stage is stalled.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/nsr_framer.sv */
// Sentence framing state machine: phase, payload count and running XOR.
// Depends on nsr_pkg; drives the write port of nsr_payload_ram.
module nsr_framer #(
  parameter int unsigned BufferDepth = 128,
  parameter int unsigned CntW        = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  output nsr_pkg::status_e    status_o,
  output logic [CntW-1:0]     count_o,
  output nsr_pkg::wr_req_t    wr_o,
  output logic [CntW-1:0]     wr_addr_o
);
  import nsr_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(BufferDepth - 1);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d, cnt_inc;
  logic [7:0]      xor_q, xor_d;
  logic            bad_char, hi_ok, lo_ok;

  assign bad_char = (byte_i == CharDollar) || (byte_i == CharCr) ||
                    (byte_i == CharLf) || byte_i[7];
  assign hi_ok    = (hex_char(xor_q[7:4]) == byte_i);
  assign lo_ok    = (hex_char(xor_q[3:0]) == byte_i);
  assign cnt_inc  = count_q + 1'b1;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        PH_PAYLOAD: begin
          if (bad_char) begin
            phase_d = PH_START;
          end else if (byte_i == CharStar) begin
            phase_d = PH_CHK_HI;
          end else if (cnt_inc >= LastCnt) begin
            phase_d = PH_START;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_CHK_HI: phase_d = hi_ok ? PH_CHK_LO : PH_START;
        PH_CHK_LO: phase_d = lo_ok ? PH_CR : PH_START;
        PH_CR:     phase_d = (byte_i == CharCr) ? PH_LF : PH_START;
        PH_LF:     phase_d = PH_START;
        default:   phase_d = (byte_i == CharDollar) ? PH_PAYLOAD : PH_START;
      endcase
    end
  end

  // Status, count, checksum and store request
  always_comb begin
    status_o = ST_IDLE;
    count_d  = count_q;
    xor_d    = xor_q;
    wr_o     = '{en: 1'b0, data: byte_i};
    if (step_i) begin
      case (phase_q)
        PH_PAYLOAD: begin
          if (bad_char) begin
            status_o = ST_BADCHAR;
          end else if (byte_i == CharStar) begin
            status_o = ST_BUSY;
          end else begin
            wr_o.en  = 1'b1;
            xor_d    = xor_q ^ byte_i;
            count_d  = cnt_inc;
            status_o = (cnt_inc >= LastCnt) ? ST_OVERFLOW : ST_BUSY;
          end
        end
        PH_CHK_HI: status_o = hi_ok ? ST_BUSY : ST_CHKSUM;
        PH_CHK_LO: status_o = lo_ok ? ST_BUSY : ST_CHKSUM;
        PH_CR:     status_o = (byte_i == CharCr) ? ST_BUSY : ST_BADEND;
        PH_LF:     status_o = (byte_i == CharLf) ? ST_VALID : ST_BADEND;
        default: begin
          if (byte_i == CharDollar) begin
            status_o = ST_BUSY;
            count_d  = '0;
            xor_d    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      count_q <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

  assign count_o   = count_d;
  assign wr_addr_o = count_q;

`ifndef SYNTH
  a_payload_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (count_q < LastCnt))
    else $error("payload phase with full buffer");

  a_hold_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(count_q) && $stable(xor_q) && $stable(phase_q)))
    else $error("framer state moved without a received byte");
`endif

endmodule
